// ----- rtl/core/matrix_keypad_debouncer_macros.svh -----
// Assertion macros for the keypad debouncer.
// Each check is active only outside synthesis.
`ifndef MATRIX_KEYPAD_DEBOUNCER_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MKD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define MKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define MKD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MKD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/mkd_pkg.sv -----
`timescale 1ns / 1ps

package mkd_pkg;

   // keypad geometry and fixed codes
   localparam int unsigned ROWS = 4;
   localparam logic [3:0] LINES_ALL = 4'hF;
   localparam logic [3:0] DEBOUNCE_RESET = 4'd5;
   localparam logic [1:0] SCAN_ROW_FIRST = 2'd0;

   // one-low column patterns
   localparam logic [3:0] PAT_COL0 = 4'hE;
   localparam logic [3:0] PAT_COL1 = 4'hD;
   localparam logic [3:0] PAT_COL2 = 4'hB;
   localparam logic [3:0] PAT_COL3 = 4'h7;

   // key map, indexed by {row, column}
   localparam logic [3:0] KEY_MAP [16] = '{
      4'd10, 4'd0, 4'd11, 4'd12,
      4'd1,  4'd2, 4'd3,  4'd13,
      4'd4,  4'd5, 4'd6,  4'd14,
      4'd7,  4'd8, 4'd9,  4'd15
   };

   typedef enum logic [1:0] {
      MODE_SCANNING   = 2'd0,
      MODE_DEBOUNCING = 2'd1,
      MODE_CLEARING   = 2'd2
   } mode_type;

   // decoded frame: a single valid press and its key
   typedef struct packed {
      logic       hit;
      logic [3:0] code;
   } key_info_type;

   // debounce machine status towards the top level
   typedef struct packed {
      logic     emit;
      mode_type mode;
   } fsm_status_type;

   // column of a one-low pattern: {valid, column}
   function automatic logic [2:0] col_of(input logic [3:0] pattern);
      logic [2:0] res;
      case (pattern)
         PAT_COL0: res = 3'b100;
         PAT_COL1: res = 3'b101;
         PAT_COL2: res = 3'b110;
         PAT_COL3: res = 3'b111;
         default:  res = 3'b000;
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/core/mkd_scan.sv -----
`timescale 1ns / 1ps

module mkd_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [1:0]                step_row,
   input  logic [3:0]                step_lines,
   output mkd_pkg::key_info_type     key_info
);

   logic [3:0] row_store_ff [mkd_pkg::ROWS];
   logic [3:0] row_store_in [mkd_pkg::ROWS];
   logic [3:0] cand;
   logic [3:0] cand_code [mkd_pkg::ROWS];

   // store the reading of the driven scan line
   always_comb begin
      row_store_in = row_store_ff;
      if (step) begin
         row_store_in[step_row] = step_lines;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mkd_pkg::ROWS; i++) begin
            row_store_ff[i] <= '0;
         end
      end else begin
         row_store_ff <= row_store_in;
      end
   end

   // per row: this row all ones, the other three equal and one-low
   for (genvar r = 0; r < mkd_pkg::ROWS; r++) begin : g_row
      localparam logic [1:0] RI = 2'(r);
      localparam logic [1:0] RA = 2'(r + 1);
      localparam logic [1:0] RB = 2'(r + 2);
      localparam logic [1:0] RC = 2'(r + 3);
      logic [2:0] col_chk;

      assign col_chk = mkd_pkg::col_of(row_store_ff[RA]);
      assign cand[r] = (row_store_ff[RI] == mkd_pkg::LINES_ALL)
                       && (row_store_ff[RA] == row_store_ff[RB])
                       && (row_store_ff[RA] == row_store_ff[RC])
                       && col_chk[2];
      assign cand_code[r] = cand[r] ? mkd_pkg::KEY_MAP[{RI, col_chk[1:0]}] : 4'd0;
   end

   // at most one candidate row can hold, so an OR merges them
   always_comb begin
      key_info.hit  = |cand;
      key_info.code = '0;
      for (int i = 0; i < mkd_pkg::ROWS; i++) begin
         key_info.code = key_info.code | cand_code[i];
      end
   end

endmodule

// ----- rtl/core/mkd_fsm.sv -----
`timescale 1ns / 1ps

module mkd_fsm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  mkd_pkg::key_info_type     key_info,
   input  logic [3:0]                debounce_frames,
   output mkd_pkg::fsm_status_type   status
);

   mkd_pkg::mode_type mode_ff;
   mkd_pkg::mode_type mode_in;
   logic [3:0]        frames_left_ff;
   logic [3:0]        frames_left_in;

   // next state, advanced once per frame (scan line 0)
   always_comb begin
      mode_in        = mode_ff;
      frames_left_in = frames_left_ff;
      if (step) begin
         case (mode_ff)
            mkd_pkg::MODE_DEBOUNCING: begin
               if (frames_left_ff <= 4'd1) begin
                  frames_left_in = '0;
                  mode_in        = mkd_pkg::MODE_CLEARING;
               end else begin
                  frames_left_in = frames_left_ff - 4'd1;
               end
            end
            mkd_pkg::MODE_CLEARING: begin
               if (!key_info.hit) begin
                  mode_in = mkd_pkg::MODE_SCANNING;
               end
            end
            default: begin
               if (key_info.hit) begin
                  frames_left_in = debounce_frames;
                  mode_in        = mkd_pkg::MODE_DEBOUNCING;
               end
            end
         endcase
      end
   end

   // outputs: a press is taken only while scanning
   always_comb begin
      status.mode = mode_ff;
      case (mode_ff)
         mkd_pkg::MODE_DEBOUNCING: status.emit = 1'b0;
         mkd_pkg::MODE_CLEARING:   status.emit = 1'b0;
         default:                  status.emit = step && key_info.hit;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= mkd_pkg::MODE_SCANNING;
         frames_left_ff <= '0;
      end else begin
         mode_ff        <= mode_in;
         frames_left_ff <= frames_left_in;
      end
   end

endmodule

// ----- rtl/core/matrix_keypad_debouncer.sv -----
`timescale 1ns / 1ps
`include "matrix_keypad_debouncer_macros.svh"

// 4x4 matrix keypad scanner with debounce. Each item is one scan step: the
// driven scan line and the four sensed lines. The readings of a whole frame
// are decoded when scan line 0 comes round again, and a single clean press
// gives one key code, after which the block waits debounce_frames frames (at
// least one) and then until the keypad is released. One item is taken every
// clock cycle unless a key code waits untaken; the input register then holds
// one further item. Items pass it and the decode and debounce logic, and a
// resulting key code is registered in the output register. debounce_frames
// must be written through csr_wr_en/csr_wr_data only while idle (unenforced).
module matrix_keypad_debouncer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_scan_row,
   input  logic [3:0] req_row_lines,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_key_code,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   logic [3:0]              frames_cfg_ff;
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [1:0]              in_row_ff;
   logic [3:0]              in_lines_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [3:0]              key_code_ff;
   logic                    advance;
   logic                    step;
   logic                    frame_step;
   mkd_pkg::key_info_type   key_info;
   mkd_pkg::fsm_status_type fsm_status;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_cfg_ff <= mkd_pkg::DEBOUNCE_RESET;
      end else if (csr_wr_en) begin
         frames_cfg_ff <= csr_wr_data;
      end
   end

   // handshake: the input stage moves on whenever the output slot is free
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;
   assign frame_step = step && (in_row_ff == mkd_pkg::SCAN_ROW_FIRST);

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_row_ff   <= req_scan_row;
         in_lines_ff <= req_row_lines;
      end
   end

   // row store and frame decode
   mkd_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .step_row   (in_row_ff),
      .step_lines (in_lines_ff),
      .key_info   (key_info)
   );

   // debounce state machine
   mkd_fsm u_fsm (
      .clock           (clock),
      .reset           (reset),
      .step            (frame_step),
      .key_info        (key_info),
      .debounce_frames (frames_cfg_ff),
      .status          (fsm_status)
   );

   // output register
   always_comb begin
      if (fsm_status.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fsm_status.emit) begin
         key_code_ff <= key_info.code;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = key_code_ff;

   // checks
   `MKD_ASSERT_IMPL(a_emit_on_frame_start, clock, reset, fsm_status.emit, frame_step && key_info.hit)
   `MKD_ASSERT_NEXT(a_emit_enters_debounce, clock, reset, fsm_status.emit, fsm_status.mode == mkd_pkg::MODE_DEBOUNCING)
   `MKD_ASSERT_IMPL(a_stall_on_full_output, clock, reset, !req_ready, in_valid_ff && rsp_valid_ff && !rsp_ready)
   `MKD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_ready, $stable(key_code_ff))

endmodule

// ----- sim/keypad_key_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the keypad debouncer, works out which key codes
// it ought to give and compares each taken key code with the oldest one due.
module keypad_key_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_scan_row,
   input  logic [3:0]  req_row_lines,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_key_code,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output int          mismatch_count,
   output int          keys_waiting,
   output int          keys_predicted,
   output int          keys_checked,
   output logic [15:0] keys_seen
);

   import mkd_pkg::*;

   // key map, indexed by {row, column}
   localparam logic [3:0] KEY_GRID [16] = '{
      4'd10, 4'd0, 4'd11, 4'd12,
      4'd1,  4'd2, 4'd3,  4'd13,
      4'd4,  4'd5, 4'd6,  4'd14,
      4'd7,  4'd8, 4'd9,  4'd15
   };

   // shadow copy of the block's register and state
   logic [3:0] frames_setting;
   logic [3:0] line_store [4];
   mode_type   mode;
   logic [3:0] frames_left;
   logic [3:0] due_keys [$];
   logic [3:0] want;
   logic [4:0] press;

   // {hit, key} for the frame held in line_store
   function automatic logic [4:0] frame_press();
      logic       seen_row;
      logic       seen_pat;
      logic       bad;
      logic [1:0] hit_row;
      logic [1:0] col;
      logic [3:0] pat;
      seen_row = 1'b0;
      seen_pat = 1'b0;
      bad      = 1'b0;
      hit_row  = 2'd0;
      col      = 2'd0;
      pat      = 4'd0;
      for (int r = 0; r < 4; r++) begin
         if (line_store[r] == LINES_ALL) begin
            if (seen_row) bad = 1'b1;
            seen_row = 1'b1;
            hit_row  = 2'(r);
         end else if (!seen_pat) begin
            seen_pat = 1'b1;
            pat      = line_store[r];
         end else if (pat != line_store[r]) begin
            bad = 1'b1;
         end
      end
      case (pat)
         PAT_COL0: col = 2'd0;
         PAT_COL1: col = 2'd1;
         PAT_COL2: col = 2'd2;
         PAT_COL3: col = 2'd3;
         default:  bad = 1'b1;
      endcase
      if (!seen_row) bad = 1'b1;
      return {!bad, KEY_GRID[{hit_row, col}]};
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frames_setting = DEBOUNCE_RESET;
         for (int r = 0; r < 4; r++) line_store[r] = 4'd0;
         mode           = MODE_SCANNING;
         frames_left    = 4'd0;
         due_keys.delete();
         mismatch_count = 0;
         keys_predicted = 0;
         keys_checked   = 0;
         keys_seen      = 16'd0;
      end else begin
         // taken key code against the oldest one due
         if (rsp_valid && rsp_ready) begin
            if (due_keys.size() == 0) begin
               note_mismatch($sformatf("key_code %0d taken with none due", rsp_key_code));
            end else begin
               want = due_keys.pop_front();
               if (rsp_key_code !== want)
                  note_mismatch($sformatf("key_code expected %0d, actual %0d",
                                          want, rsp_key_code));
               keys_checked++;
               keys_seen[want] = 1'b1;
            end
         end

         if (csr_wr_en) frames_setting = csr_wr_data;

         // scan step: decode last frame on line 0, then store the reading
         if (req_valid && req_ready) begin
            if (req_scan_row == SCAN_ROW_FIRST) begin
               press = frame_press();
               case (mode)
                  MODE_DEBOUNCING: begin
                     if (frames_left <= 4'd1) begin
                        frames_left = 4'd0;
                        mode        = MODE_CLEARING;
                     end else begin
                        frames_left = frames_left - 4'd1;
                     end
                  end
                  MODE_CLEARING: begin
                     if (!press[4]) mode = MODE_SCANNING;
                  end
                  default: begin
                     if (press[4]) begin
                        frames_left = frames_setting;
                        mode        = MODE_DEBOUNCING;
                        due_keys.push_back(press[3:0]);
                        keys_predicted++;
                     end
                  end
               endcase
            end
            line_store[req_scan_row] = req_row_lines;
         end
      end
      keys_waiting = due_keys.size();
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

   import mkd_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int HOLD_CYCLES    = 400;
   localparam int STALL_LIMIT    = 4000;
   localparam int PHASE_ITEMS    = 180;
   localparam int PHASE_KEYS     = 4;
   localparam int DRAIN_CYCLES   = 6;
   localparam int PHASES         = 8;
   localparam int PRESSURE_PHASE = 4;

   localparam logic [3:0] COL_PAT [4] = '{PAT_COL0, PAT_COL1, PAT_COL2, PAT_COL3};
   localparam logic [3:0] PHASE_FRAMES [PHASES] = '{
      4'd1, 4'd15, 4'd0, 4'd3, 4'd9, 4'd2, 4'd15, 4'd1
   };
   localparam idle_mode_type PHASE_IDLE [PHASES] = '{
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_scan_row;
   logic [3:0]  req_row_lines;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_key_code;
   logic        csr_wr_en;
   logic [3:0]  csr_wr_data;

   int          mismatches;
   int          keys_waiting;
   int          keys_predicted;
   int          keys_checked;
   logic [15:0] keys_seen;

   int          send_gap_pct;
   int          stall_pct;
   bit          hold_request;
   int          scans_sent;
   int          quiet_cycles;

   matrix_keypad_debouncer uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_scan_row  (req_scan_row),
      .req_row_lines (req_row_lines),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_code  (rsp_key_code),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   keypad_key_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_scan_row   (req_scan_row),
      .req_row_lines  (req_row_lines),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_code   (rsp_key_code),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatches),
      .keys_waiting   (keys_waiting),
      .keys_predicted (keys_predicted),
      .keys_checked   (keys_checked),
      .keys_seen      (keys_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog: too long without any item moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic set_idle(input idle_mode_type m);
      send_gap_pct = (m == IDLE_SENDER) ? 84 : (m == IDLE_BOTH) ? 13 : 0;
      stall_pct    = (m == IDLE_RECEIVER) ? 84 : (m == IDLE_BOTH) ? 13 : 0;
   endtask

   // offer one scan step; returns at the falling edge after it is taken
   task automatic send_scan(input logic [1:0] row, input logic [3:0] lines);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_scan_row  <= row;
      req_row_lines <= lines;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      scans_sent++;
   endtask

   task automatic send_frame(input logic [3:0] l0, input logic [3:0] l1,
                             input logic [3:0] l2, input logic [3:0] l3);
      send_scan(2'd0, l0);
      send_scan(2'd1, l1);
      send_scan(2'd2, l2);
      send_scan(2'd3, l3);
   endtask

   // one frame with key (h, c) held; some lines may bounce
   task automatic press_frame(input int h, input int c, input int bounce_pct);
      logic [3:0] lines;
      for (int r = 0; r < 4; r++) begin
         lines = (r == h) ? LINES_ALL : COL_PAT[c];
         if ($urandom_range(99) < bounce_pct) lines = 4'($urandom_range(15));
         send_scan(2'(r), lines);
      end
   endtask

   task automatic release_frame();
      logic [3:0] lines;
      lines = ($urandom_range(3) == 0) ? 4'd0 : LINES_ALL;
      send_frame(lines, lines, lines, lines);
   endtask

   // mostly whole presses, some line noise and some shuffled frames
   task automatic random_burst();
      int pick;
      int h;
      int c;
      int n;
      pick = $urandom_range(99);
      h    = $urandom_range(3);
      c    = $urandom_range(3);
      if (pick < 70) begin
         repeat ($urandom_range(2)) press_frame(h, c, 30);
         repeat ($urandom_range(1, 8)) press_frame(h, c, 0);
         repeat ($urandom_range(1, 3)) release_frame();
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 8))
            send_scan(2'($urandom_range(3)), 4'($urandom_range(15)));
      end else begin
         for (int k = 0; k < 4; k++) begin
            n = $urandom_range(3);
            send_scan(2'(n), (n == h) ? LINES_ALL : COL_PAT[c]);
         end
      end
   endtask

   // all due key codes taken, then a drain wait for steps still in flight
   task automatic wait_quiet();
      while (keys_waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_debounce(input logic [3:0] frames);
      req_valid <= 1'b0;
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= frames;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int first_key;
      int target;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_scan_row  = 2'd0;
      req_row_lines = 4'd0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 4'd0;
      hold_request  = 1'b0;
      scans_sent    = 0;
      set_idle(IDLE_NONE);
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed frames at the reset debounce setting
      send_frame(LINES_ALL, LINES_ALL, LINES_ALL, LINES_ALL); // several full rows
      send_frame(4'h0, 4'h0, 4'h0, 4'h0);                     // no full row
      send_frame(LINES_ALL, 4'hC, 4'hC, 4'hC);                // two lines low
      send_frame(LINES_ALL, PAT_COL0, PAT_COL1, PAT_COL0);    // patterns disagree
      send_frame(PAT_COL3, PAT_COL3, PAT_COL3, LINES_ALL);    // clean press, key 15
      send_frame(PAT_COL0, LINES_ALL, PAT_COL0, PAT_COL0);    // new key while debouncing
      send_scan(SCAN_ROW_FIRST, 4'h0);

      // random phases, each with its own debounce setting and idling
      for (int p = 0; p < PHASES; p++) begin
         write_debounce(PHASE_FRAMES[p]);
         set_idle(PHASE_IDLE[p]);
         if (p == PRESSURE_PHASE) hold_request = 1'b1;
         first_key = keys_predicted;
         target    = scans_sent + PHASE_ITEMS;
         while (scans_sent < target || keys_predicted - first_key < PHASE_KEYS)
            random_burst();
      end

      req_valid <= 1'b0;
      set_idle(IDLE_NONE);
      wait_quiet();

      $display("Run covered %0d scan steps over %0d debounce settings, idling on either side",
               scans_sent, PHASES);
      $display("and a long receiver hold-off; %0d key codes checked, %0d of 16 keys seen.",
               keys_checked, $countones(keys_seen));
      if (mismatches == 0 && keys_waiting == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
